// File: sv/gbp_pkg.sv
package gbp_pkg;

   localparam int ADDR_W = 64;
   localparam int HIST_W = 14;
   localparam int TIDX_W = 14;
   localparam int CNT_W = 32;
   localparam int CTR_W = 2;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int LEN_W = 5;

   localparam logic [CTR_W-1:0] COUNTER_RESET = 2'd2;
   localparam logic [CTR_W-1:0] COUNTER_MAX = 2'd3;
   localparam logic [CTR_W-1:0] COUNTER_MIN = 2'd0;
   localparam logic [CTR_W-1:0] TAKEN_THRESHOLD = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INDEX_BITS = 1'b0,
      CSR_HISTORY_BITS = 1'b1
   } csr_index_type;

endpackage

// File: sv/gbp_channels.sv
interface gbp_req_if
   import gbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] branch_address;
   logic              branch_taken;

   modport source (output valid, output branch_address, output branch_taken, input ready);
   modport sink (input valid, input branch_address, input branch_taken, output ready);
endinterface

interface gbp_rsp_if
   import gbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              predicted_taken;
   logic              mispredicted;
   logic [TIDX_W-1:0] table_index;
   logic [CNT_W-1:0]  prediction_count;
   logic [CNT_W-1:0]  mispredict_count;

   modport source (output valid, output predicted_taken, output mispredicted,
                   output table_index, output prediction_count,
                   output mispredict_count, input ready);
   modport sink (input valid, input predicted_taken, input mispredicted,
                 input table_index, input prediction_count,
                 input mispredict_count, output ready);
endinterface

// File: sv/gshare_branch_predictor.sv
// Gshare branch predictor with a table of 2-bit saturating counters held in one
// synchronous memory. After reset the block sweeps the table to weakly taken, one
// entry per cycle, and accepts no item until the sweep is done; configuration
// writes are taken throughout. After that it takes one item per cycle as long as
// results are taken: the index and the new history are formed in the cycle of
// acceptance, the memory is read at that edge, and the counter is updated and
// written back when the item leaves the stage after the read, with the write
// forwarded to a following item that uses the same entry. The result is registered
// at that write-back edge. While a result waits, one more item is held in the
// pipeline and the input then stalls until the result is taken.
module gshare_branch_predictor
   import gbp_pkg::*;
#(
   parameter int MAX_INDEX_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   gbp_req_if.sink              req_ch,
   gbp_rsp_if.source            rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int AW = MAX_INDEX_BITS;
   localparam int DEPTH = 1 << AW;

   logic [CTR_W-1:0] table_mem [DEPTH];

   logic [CSR_DATA_W-1:0] index_bits_ff, index_bits_in;
   logic [CSR_DATA_W-1:0] history_bits_ff, history_bits_in;
   logic [HIST_W-1:0]     history_ff, history_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [AW-1:0]         s1_idx_ff;
   logic                  s1_taken_ff;
   logic                  fwd_hit_ff;
   logic [CTR_W-1:0]      fwd_val_ff;
   logic [CTR_W-1:0]      rd_ff;
   logic [CNT_W-1:0]      pred_cnt_ff, pred_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pred_ff;
   logic                  rsp_miss_ff;
   logic [TIDX_W-1:0]     rsp_idx_ff;

   logic [LEN_W-1:0]      m_eff;
   logic [LEN_W-1:0]      n_eff;
   logic [LEN_W-1:0]      hist_shift;
   logic [AW:0]           mask_w;
   logic [AW-1:0]         mask;
   logic [AW-1:0]         addr_part;
   logic [HIST_W+AW-1:0]  hist_wide;
   logic [AW-1:0]         hist_part;
   logic [AW-1:0]         req_idx;
   logic [HIST_W:0]       hist_next_w;
   logic                  accept;
   logic                  s1_adv;
   logic [CTR_W-1:0]      s1_ctr;
   logic                  s1_pred;
   logic                  s1_miss;
   logic [CTR_W-1:0]      s1_ctr_new;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [CTR_W-1:0]      mem_wd;
   logic [AW+TIDX_W-1:0]  s1_idx_ext;

   always_comb begin
      if (index_bits_ff == '0) begin
         m_eff = LEN_W'(1);
      end else if (LEN_W'(index_bits_ff) > LEN_W'(MAX_INDEX_BITS)) begin
         m_eff = LEN_W'(MAX_INDEX_BITS);
      end else begin
         m_eff = LEN_W'(index_bits_ff);
      end
      if (LEN_W'(history_bits_ff) > m_eff) begin
         n_eff = m_eff;
      end else begin
         n_eff = LEN_W'(history_bits_ff);
      end
      hist_shift = m_eff - n_eff;
      mask_w = ((AW+1)'(1) << m_eff) - (AW+1)'(1);
      mask = mask_w[AW-1:0];
      addr_part = req_ch.branch_address[AW+1:2] & mask;
      hist_wide = (HIST_W+AW)'(history_ff) << hist_shift;
      hist_part = hist_wide[AW-1:0] & mask;
      req_idx = (addr_part ^ hist_part) & mask;
      hist_next_w = (HIST_W+1)'(history_ff >> 1);
      if (req_ch.branch_taken && n_eff != '0) begin
         hist_next_w = hist_next_w | ((HIST_W+1)'(1) << (n_eff - LEN_W'(1)));
      end
   end

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_ctr = fwd_hit_ff ? fwd_val_ff : rd_ff;
      s1_pred = s1_ctr >= TAKEN_THRESHOLD;
      s1_miss = s1_pred != s1_taken_ff;
      s1_ctr_new = s1_ctr;
      if (s1_taken_ff) begin
         if (s1_ctr != COUNTER_MAX) begin
            s1_ctr_new = s1_ctr + CTR_W'(1);
         end
      end else begin
         if (s1_ctr != COUNTER_MIN) begin
            s1_ctr_new = s1_ctr - CTR_W'(1);
         end
      end
      s1_idx_ext = (AW+TIDX_W)'(s1_idx_ff);
   end

   always_comb begin
      mem_we = clr_busy_ff || s1_adv;
      mem_wa = clr_busy_ff ? clr_addr_ff : s1_idx_ff;
      mem_wd = clr_busy_ff ? COUNTER_RESET : s1_ctr_new;
   end

   always_comb begin
      index_bits_in = index_bits_ff;
      history_bits_in = history_bits_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INDEX_BITS: begin
               index_bits_in = csr_write_data;
            end
            CSR_HISTORY_BITS: begin
               history_bits_in = csr_write_data;
            end
         endcase
      end
      history_in = accept ? hist_next_w[HIST_W-1:0] : history_ff;
      clr_busy_in = clr_busy_ff && (clr_addr_ff != '1);
      clr_addr_in = clr_busy_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      pred_cnt_in = pred_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (s1_adv) begin
         if (pred_cnt_ff != '1) begin
            pred_cnt_in = pred_cnt_ff + CNT_W'(1);
         end
         if (s1_miss && miss_cnt_ff != '1) begin
            miss_cnt_in = miss_cnt_ff + CNT_W'(1);
         end
      end
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= CSR_DATA_W'(14);
         history_bits_ff <= '0;
         history_ff <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         pred_cnt_ff <= '0;
         miss_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_bits_ff <= index_bits_in;
         history_bits_ff <= history_bits_in;
         history_ff <= history_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         pred_cnt_ff <= pred_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff <= req_idx;
         s1_taken_ff <= req_ch.branch_taken;
         fwd_hit_ff <= s1_adv && (s1_idx_ff == req_idx);
         fwd_val_ff <= s1_ctr_new;
      end
      if (s1_adv) begin
         rsp_pred_ff <= s1_pred;
         rsp_miss_ff <= s1_miss;
         rsp_idx_ff <= s1_idx_ext[TIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_ff <= table_mem[req_idx];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.predicted_taken = rsp_pred_ff;
   assign rsp_ch.mispredicted = rsp_miss_ff;
   assign rsp_ch.table_index = rsp_idx_ff;
   assign rsp_ch.prediction_count = pred_cnt_ff;
   assign rsp_ch.mispredict_count = miss_cnt_ff;

endmodule

// File: sv/gbp_checker.sv
module gbp_checker
   import gbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_mispredicted,
   input logic [TIDX_W-1:0] rsp_table_index,
   input logic [CNT_W-1:0]  rsp_prediction_count,
   input logic [CNT_W-1:0]  rsp_mispredict_count
);

   // The table sweep after reset keeps the input side closed.
   a_ready_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input ready right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_table_index)
         && $stable(rsp_prediction_count) && $stable(rsp_mispredict_count))
      else $error("stalled result changed");

   a_miss_le_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mispredict_count <= rsp_prediction_count
         && (!rsp_mispredicted || rsp_mispredict_count != '0))
      else $error("mispredict total inconsistent with result");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_mispredicted     (rsp_ch.mispredicted),
   .rsp_table_index      (rsp_ch.table_index),
   .rsp_prediction_count (rsp_ch.prediction_count),
   .rsp_mispredict_count (rsp_ch.mispredict_count)
);
